### hdl/frac_red_pkg.sv
// shared types and constants for the fraction arithmetic and reduction block
package frac_red_pkg;

    // result field width, fixed by the interface
    localparam int OUT_W = 33;
    // operation code width
    localparam int CMD_W = 2;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // which product the shared multiplier forms
    typedef enum logic [1:0] {
        MUL_NUM0,
        MUL_CROSS,
        MUL_DEN
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_COMBINE,
        S_CHECK,
        S_GCD,
        S_DIV_NUM,
        S_SAVE_NUM,
        S_DIV_DEN,
        S_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     combine;
        logic     gcd_load;
        logic     gcd_step;
        logic     div_load_num;
        logic     div_step;
        logic     save_num;
        logic     out_load;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic num_zero;
        logic den_zero;
        logic gcd_equal;
        logic div_last;
    } dp_status_t;

endpackage

### hdl/frac_red_dp.sv
// datapath: shared multiplier, sign-magnitude combine, binary gcd and restoring divider
module frac_red_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                             clk,
    input  frac_red_pkg::ctrl_cmd_t          cmd,
    output frac_red_pkg::dp_status_t         status,
    input  logic [frac_red_pkg::CMD_W-1:0]   command,
    input  logic signed [OPERAND_WIDTH-1:0]  a_num,
    input  logic signed [OPERAND_WIDTH-1:0]  a_den,
    input  logic signed [OPERAND_WIDTH-1:0]  b_num,
    input  logic signed [OPERAND_WIDTH-1:0]  b_den,
    output logic signed [frac_red_pkg::OUT_W-1:0] result_num,
    output logic signed [frac_red_pkg::OUT_W-1:0] result_den,
    output logic                             zero_denominator
);
    import frac_red_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * OPERAND_WIDTH;
    localparam int KW = $clog2(MW + 1);
    localparam int XW = (MW > OUT_W) ? MW : OUT_W;

    // captured operands as sign and magnitude
    op_t            op_reg;
    logic [W-1:0]   an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic           an_neg_reg, ad_neg_reg, bn_neg_reg, bd_neg_reg;

    // products and their signs
    logic [MW-1:0]  p0_reg, p1_reg, p2_reg;
    logic           s0_reg, s1_reg, s2_reg;

    // unreduced result
    logic [MW-1:0]  num_mag_reg, den_mag_reg;
    logic           num_neg_reg, den_neg_reg;

    // gcd state
    logic [MW-1:0]  gx_reg, gy_reg;
    logic [KW-1:0]  gk_reg;

    // divider state
    logic [MW-1:0]  div_q_reg, div_r_reg, div_d_reg;
    logic [KW-1:0]  div_cnt_reg;

    // output register
    logic signed [OUT_W-1:0] res_num_reg, res_den_reg;
    logic                    zero_den_reg;

    logic [W-1:0]   mul_a, mul_b;
    logic           mul_s;
    logic [MW-1:0]  product;
    logic [MW-1:0]  comb_num_mag;
    logic           comb_num_neg, comb_den_neg, cross_neg;
    logic [MW-1:0]  comb_den_mag;
    logic [MW-1:0]  gcd_val;
    logic [MW:0]    div_shift, div_trial;
    logic           div_ge;
    logic [XW-1:0]  num_ext, num_bits, den_ext, den_bits;

    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        mag_of = v[W-1] ? (~v + W'(1)) : v;
    endfunction

    // operand capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(command);
            an_mag_reg <= mag_of(a_num);
            ad_mag_reg <= mag_of(a_den);
            bn_mag_reg <= mag_of(b_num);
            bd_mag_reg <= mag_of(b_den);
            an_neg_reg <= a_num[W-1];
            ad_neg_reg <= a_den[W-1];
            bn_neg_reg <= b_num[W-1];
            bd_neg_reg <= b_den[W-1];
        end
    end

    // shared multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_NUM0:
            begin
                mul_a = an_mag_reg;
                mul_b = (op_reg == OP_MUL) ? bn_mag_reg : bd_mag_reg;
                mul_s = an_neg_reg ^ ((op_reg == OP_MUL) ? bn_neg_reg : bd_neg_reg);
            end
            MUL_CROSS:
            begin
                mul_a = ad_mag_reg;
                mul_b = bn_mag_reg;
                mul_s = ad_neg_reg ^ bn_neg_reg;
            end
            default:
            begin
                mul_a = ad_mag_reg;
                mul_b = bd_mag_reg;
                mul_s = ad_neg_reg ^ bd_neg_reg;
            end
        endcase
        product = MW'(mul_a) * MW'(mul_b);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_sel)
                MUL_NUM0:
                begin
                    p0_reg <= product;
                    s0_reg <= mul_s;
                end
                MUL_CROSS:
                begin
                    p1_reg <= product;
                    s1_reg <= mul_s;
                end
                default:
                begin
                    p2_reg <= product;
                    s2_reg <= mul_s;
                end
            endcase
        end
    end

    // combine products into unreduced numerator and denominator
    always_comb
    begin
        cross_neg    = s1_reg ^ (op_reg == OP_SUB);
        comb_num_mag = p0_reg;
        comb_num_neg = s0_reg;
        comb_den_mag = p2_reg;
        comb_den_neg = s2_reg;
        unique case (op_reg)
            OP_ADD, OP_SUB:
            begin
                priority if (s0_reg == cross_neg)
                begin
                    comb_num_mag = p0_reg + p1_reg;
                    comb_num_neg = s0_reg;
                end
                else if (p0_reg >= p1_reg)
                begin
                    comb_num_mag = p0_reg - p1_reg;
                    comb_num_neg = s0_reg;
                end
                else
                begin
                    comb_num_mag = p1_reg - p0_reg;
                    comb_num_neg = cross_neg;
                end
            end
            OP_MUL:
            begin
                comb_den_mag = p2_reg;
                comb_den_neg = s2_reg;
            end
            default:
            begin
                comb_den_mag = p1_reg;
                comb_den_neg = s1_reg;
            end
        endcase
    end

    // gcd value and divider trial subtraction
    always_comb
    begin
        gcd_val   = gx_reg << gk_reg;
        div_shift = {div_r_reg, div_q_reg[MW-1]};
        div_trial = div_shift - {1'b0, div_d_reg};
        div_ge    = ~div_trial[MW];
    end

    // unreduced result, reduced numerator saved after its division
    always_ff @(posedge clk)
    begin
        if (cmd.combine)
        begin
            num_mag_reg <= comb_num_mag;
            num_neg_reg <= comb_num_neg;
            den_mag_reg <= comb_den_mag;
            den_neg_reg <= comb_den_neg;
        end
        else if (cmd.save_num)
        begin
            num_mag_reg <= div_q_reg;
        end
    end

    // binary gcd, one step a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.gcd_load)
        begin
            gx_reg <= num_mag_reg;
            gy_reg <= den_mag_reg;
            gk_reg <= '0;
        end
        else if (cmd.gcd_step)
        begin
            priority if (!gx_reg[0] && !gy_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
                gy_reg <= gy_reg >> 1;
                gk_reg <= gk_reg + KW'(1);
            end
            else if (!gx_reg[0])
            begin
                gx_reg <= gx_reg >> 1;
            end
            else if (!gy_reg[0])
            begin
                gy_reg <= gy_reg >> 1;
            end
            else if (gx_reg > gy_reg)
            begin
                gx_reg <= gx_reg - gy_reg;
            end
            else
            begin
                gy_reg <= gy_reg - gx_reg;
            end
        end
    end

    // restoring divider, one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.div_load_num)
        begin
            div_q_reg   <= num_mag_reg;
            div_r_reg   <= '0;
            div_d_reg   <= gcd_val;
            div_cnt_reg <= '0;
        end
        else if (cmd.save_num)
        begin
            div_q_reg   <= den_mag_reg;
            div_r_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_q_reg   <= {div_q_reg[MW-2:0], div_ge};
            div_r_reg   <= div_ge ? div_trial[MW-1:0] : div_shift[MW-1:0];
            div_cnt_reg <= div_cnt_reg + KW'(1);
        end
    end

    // signed result fields, low bits of the two's complement value
    always_comb
    begin
        num_ext  = XW'(num_mag_reg);
        num_bits = num_neg_reg ? (~num_ext + XW'(1)) : num_ext;
        den_ext  = XW'(div_q_reg);
        den_bits = den_neg_reg ? (~den_ext + XW'(1)) : den_ext;
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            priority if (den_mag_reg == '0)
            begin
                res_num_reg  <= '0;
                res_den_reg  <= '0;
                zero_den_reg <= 1'b1;
            end
            else if (num_mag_reg == '0)
            begin
                res_num_reg  <= '0;
                res_den_reg  <= OUT_W'(1);
                zero_den_reg <= 1'b0;
            end
            else
            begin
                res_num_reg  <= num_bits[OUT_W-1:0];
                res_den_reg  <= den_bits[OUT_W-1:0];
                zero_den_reg <= 1'b0;
            end
        end
    end

    assign status.num_zero  = (num_mag_reg == '0);
    assign status.den_zero  = (den_mag_reg == '0);
    assign status.gcd_equal = (gx_reg == gy_reg);
    assign status.div_last  = (div_cnt_reg == KW'(MW - 1));

    assign result_num       = res_num_reg;
    assign result_den       = res_den_reg;
    assign zero_denominator = zero_den_reg;

endmodule

### hdl/frac_red_ctrl.sv
// controller: sequences multiply, combine, gcd and the two divisions, owns both handshakes
module frac_red_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    output logic                      req_stall,
    output logic                      rsp_valid,
    input  logic                      rsp_stall,
    input  frac_red_pkg::dp_status_t  status,
    output frac_red_pkg::ctrl_cmd_t   cmd
);
    import frac_red_pkg::*;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    // state and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.mul_sel    = MUL_NUM0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_NUM0;
                state_next  = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_CROSS;
                state_next  = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DEN;
                state_next  = S_COMBINE;
            end
            S_COMBINE:
            begin
                cmd.combine = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.den_zero || status.num_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.gcd_load = 1'b1;
                    state_next   = S_GCD;
                end
            end
            S_GCD:
            begin
                if (status.gcd_equal)
                begin
                    cmd.div_load_num = 1'b1;
                    state_next       = S_DIV_NUM;
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                end
            end
            S_DIV_NUM:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_SAVE_NUM;
                end
            end
            S_SAVE_NUM:
            begin
                cmd.save_num = 1'b1;
                state_next   = S_DIV_DEN;
            end
            S_DIV_DEN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

### hdl/fraction_arith_reduce_top.sv
// top level of the fraction arithmetic and reduction block
//
//  channel  signals                                  direction  moves
//  req      req_valid/req_stall, command, a_*, b_*   in         one operand word
//  rsp      rsp_valid/rsp_stall, result_*, zero_den  out        one result word
//
// one word at a time: load, three products on the shared multiplier, combine and zero check,
// then a binary gcd (one step a cycle) and two restoring divisions of 2*OPERAND_WIDTH
// quotient bits each; zero results skip gcd and division.
// the result sits in an output register, so a new word is taken while it waits.
// asynchronous active-low reset clears the controller and the output valid.
module fraction_arith_reduce_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_stall,
    input  logic [frac_red_pkg::CMD_W-1:0]         command,
    input  logic signed [OPERAND_WIDTH-1:0]        a_num,
    input  logic signed [OPERAND_WIDTH-1:0]        a_den,
    input  logic signed [OPERAND_WIDTH-1:0]        b_num,
    input  logic signed [OPERAND_WIDTH-1:0]        b_den,
    output logic                                   rsp_valid,
    input  logic                                   rsp_stall,
    output logic signed [frac_red_pkg::OUT_W-1:0]  result_num,
    output logic signed [frac_red_pkg::OUT_W-1:0]  result_den,
    output logic                                   zero_denominator
);
    import frac_red_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    frac_red_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic
    frac_red_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk              (clk),
        .cmd              (cmd),
        .status           (status),
        .command          (command),
        .a_num            (a_num),
        .a_den            (a_den),
        .b_num            (b_num),
        .b_den            (b_den),
        .result_num       (result_num),
        .result_den       (result_den),
        .zero_denominator (zero_denominator)
    );

endmodule

### hdl/frac_red_chk.sv
// port-level checks for the fraction arithmetic and reduction block, bound to the top level
module frac_red_chk (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   req_valid,
    input logic                                   req_stall,
    input logic                                   rsp_valid,
    input logic                                   rsp_stall,
    input logic signed [frac_red_pkg::OUT_W-1:0]  result_num,
    input logic signed [frac_red_pkg::OUT_W-1:0]  result_den,
    input logic                                   zero_denominator
);
    import frac_red_pkg::*;

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(result_num) && $stable(result_den)
            && $stable(zero_denominator))
    else $error("stalled result word changed");

    // block is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
    else $error("second word taken while first is in work");

    // zero denominator flag comes with a zeroed result
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && zero_denominator |-> result_num == '0 && result_den == '0)
    else $error("flagged result not zeroed");

    // an unflagged valid result never has a zero denominator
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !zero_denominator |-> result_den != '0)
    else $error("unflagged result with zero denominator");

    // zero numerator reduces to 0/1
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !zero_denominator && result_num == '0 |-> result_den == OUT_W'(1))
    else $error("zero numerator not reduced to one");

endmodule

bind fraction_arith_reduce_top frac_red_chk u_frac_red_chk (.*);
